@@ src/ps2a_pkg.sv @@
// Package with types, scancode constants and the set-1 translation table.
package ps2a_pkg;

    localparam logic [7:0] SC_PREFIX = 8'hE0;
    localparam logic [7:0] SC_BREAK  = 8'h80;
    localparam logic [7:0] SC_DELETE = 8'h53;
    localparam logic [6:0] ASCII_DEL = 7'h7F;
    localparam logic [6:0] ASCII_NUL = 7'h00;

    localparam logic KIND_SCAN = 1'b0;
    localparam logic KIND_READ = 1'b1;

    localparam int RES_DEPTH = 3;

    typedef struct packed {
        logic       char_valid;
        logic [6:0] char_code;
        logic       dropped_oldest;
        logic [7:0] fill_level;
    } res_item_t;

    // Set-1 make code to lower-case ASCII; zero for unmapped codes.
    function automatic logic [6:0] make_to_ascii(input logic [7:0] sc);
        logic [6:0] ch;
        ch = ASCII_NUL;
        case (sc)
            8'h01: ch = 7'h1B;
            8'h02: ch = 7'h31;
            8'h03: ch = 7'h32;
            8'h04: ch = 7'h33;
            8'h05: ch = 7'h34;
            8'h06: ch = 7'h35;
            8'h07: ch = 7'h36;
            8'h08: ch = 7'h37;
            8'h09: ch = 7'h38;
            8'h0A: ch = 7'h39;
            8'h0B: ch = 7'h30;
            8'h0C: ch = 7'h2D;
            8'h0D: ch = 7'h3D;
            8'h0E: ch = 7'h08;
            8'h0F: ch = 7'h09;
            8'h10: ch = 7'h71;
            8'h11: ch = 7'h77;
            8'h12: ch = 7'h65;
            8'h13: ch = 7'h72;
            8'h14: ch = 7'h74;
            8'h15: ch = 7'h79;
            8'h16: ch = 7'h75;
            8'h17: ch = 7'h69;
            8'h18: ch = 7'h6F;
            8'h19: ch = 7'h70;
            8'h1A: ch = 7'h5B;
            8'h1B: ch = 7'h5D;
            8'h1C: ch = 7'h0A;
            8'h1E: ch = 7'h61;
            8'h1F: ch = 7'h73;
            8'h20: ch = 7'h64;
            8'h21: ch = 7'h66;
            8'h22: ch = 7'h67;
            8'h23: ch = 7'h68;
            8'h24: ch = 7'h6A;
            8'h25: ch = 7'h6B;
            8'h26: ch = 7'h6C;
            8'h27: ch = 7'h3B;
            8'h28: ch = 7'h27;
            8'h29: ch = 7'h60;
            8'h2B: ch = 7'h5C;
            8'h2C: ch = 7'h7A;
            8'h2D: ch = 7'h78;
            8'h2E: ch = 7'h63;
            8'h2F: ch = 7'h76;
            8'h30: ch = 7'h62;
            8'h31: ch = 7'h6E;
            8'h32: ch = 7'h6D;
            8'h33: ch = 7'h2C;
            8'h34: ch = 7'h2E;
            8'h35: ch = 7'h2F;
            8'h39: ch = 7'h20;
            default: ch = ASCII_NUL;
        endcase
        return ch;
    endfunction

endpackage

@@ src/ps2a_if.sv @@
// Valid/ready channel interfaces for scancode requests and character results.
interface ps2a_req_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] scan_byte;

    modport source (output valid, output kind, output scan_byte, input ready);
    modport sink   (input valid, input kind, input scan_byte, output ready);
endinterface

interface ps2a_res_if;
    logic       valid;
    logic       ready;
    logic       char_valid;
    logic [6:0] char_code;
    logic       dropped_oldest;
    logic [7:0] fill_level;

    modport source (output valid, output char_valid, output char_code,
                    output dropped_oldest, output fill_level, input ready);
    modport sink   (input valid, input char_valid, input char_code,
                    input dropped_oldest, input fill_level, output ready);
endinterface

@@ src/ps2_scancode_to_ascii_fifo.sv @@
// Top level: set-1 scancode translator feeding a character ring buffer in block memory.
// Each transfer on scan_in either delivers a raw set-1 scancode byte (kind 0) or asks
// for the oldest buffered character (kind 1), and produces exactly one result on
// char_out. One item is taken per clock cycle while scan_in.ready is high; its result
// passes through the registered read of the character memory and then through
// a three-entry result queue. scan_in.ready is driven only from registers and drops
// when that queue and the memory-read stage together hold three results, so a stalled
// char_out throttles input after at most three items. The ring holds up to
// BUFFER_DEPTH-1 characters; a store into a full ring overwrites the oldest one and
// flags dropped_oldest. fill_level saturates at 255.
module ps2_scancode_to_ascii_fifo #(
    parameter int BUFFER_DEPTH = 256
) (
    input  logic         clk,
    input  logic         rst_n,
    ps2a_req_if.sink     scan_in,
    ps2a_res_if.source   char_out
);

    localparam int PTR_W = $clog2(BUFFER_DEPTH);

    logic [6:0] store_mem [BUFFER_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] count_reg, count_next;
    logic             ext_reg, ext_next;

    logic                s1_valid_reg;
    logic                s1_pop_reg;
    ps2a_pkg::res_item_t s1_item_reg, s1_item_next;
    logic [6:0]          rd_data_reg;

    logic       accept;
    logic       do_store;
    logic       do_pop;
    logic       ring_full;
    logic       ring_empty;
    logic [6:0] trans_char;

    logic                fifo_not_empty;
    logic [1:0]          fifo_count;
    ps2a_pkg::res_item_t fifo_push_item;
    ps2a_pkg::res_item_t fifo_head;
    logic                fifo_pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    // Hold off input while the queue plus the read stage could overflow.
    assign scan_in.ready = ({1'b0, fifo_count} + {2'b00, s1_valid_reg})
                           < 3'(ps2a_pkg::RES_DEPTH);
    assign accept = scan_in.valid && scan_in.ready;

    always_comb
    begin
        ext_next   = ext_reg;
        trans_char = ps2a_pkg::ASCII_NUL;
        if (ext_reg)
        begin
            ext_next = 1'b0;
            if (scan_in.scan_byte == ps2a_pkg::SC_DELETE)
            begin
                trans_char = ps2a_pkg::ASCII_DEL;
            end
        end
        else if (scan_in.scan_byte == ps2a_pkg::SC_PREFIX)
        begin
            ext_next = 1'b1;
        end
        else if (scan_in.scan_byte < ps2a_pkg::SC_BREAK)
        begin
            trans_char = ps2a_pkg::make_to_ascii(scan_in.scan_byte);
        end
    end

    assign ring_full  = (count_reg == PTR_W'(BUFFER_DEPTH - 1));
    assign ring_empty = (count_reg == '0);
    assign do_store   = accept && (scan_in.kind == ps2a_pkg::KIND_SCAN)
                        && (trans_char != ps2a_pkg::ASCII_NUL);
    assign do_pop     = accept && (scan_in.kind == ps2a_pkg::KIND_READ) && !ring_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_store)
        begin
            wr_ptr_next = ptr_inc(wr_ptr_reg);
            if (ring_full)
            begin
                // Overwrite: drop the oldest entry, level stays put.
                rd_ptr_next = ptr_inc(rd_ptr_reg);
            end
            else
            begin
                count_next = count_reg + PTR_W'(1);
            end
        end
        else if (do_pop)
        begin
            rd_ptr_next = ptr_inc(rd_ptr_reg);
            count_next  = count_reg - PTR_W'(1);
        end
    end

    always_comb
    begin
        s1_item_next.char_valid     = do_store || do_pop;
        s1_item_next.char_code      = do_store ? trans_char : ps2a_pkg::ASCII_NUL;
        s1_item_next.dropped_oldest = do_store && ring_full;
        s1_item_next.fill_level     = (32'(count_next) > 32'd255) ? 8'hFF : 8'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            count_reg    <= '0;
            ext_reg      <= 1'b0;
            s1_valid_reg <= 1'b0;
            s1_pop_reg   <= 1'b0;
        end
        else
        begin
            wr_ptr_reg   <= wr_ptr_next;
            rd_ptr_reg   <= rd_ptr_next;
            count_reg    <= count_next;
            s1_valid_reg <= accept;
            s1_pop_reg   <= do_pop;
            if (accept && (scan_in.kind == ps2a_pkg::KIND_SCAN))
            begin
                ext_reg <= ext_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= s1_item_next;
        end
    end

    // One access per cycle: a write lands before any later read of the same entry.
    always_ff @(posedge clk)
    begin
        if (do_store)
        begin
            store_mem[wr_ptr_reg] <= trans_char;
        end
        if (do_pop)
        begin
            rd_data_reg <= store_mem[rd_ptr_reg];
        end
    end

    always_comb
    begin
        fifo_push_item = s1_item_reg;
        if (s1_pop_reg)
        begin
            fifo_push_item.char_code = rd_data_reg;
        end
    end

    assign fifo_pop = char_out.valid && char_out.ready;

    ps2a_res_fifo u_res_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s1_valid_reg),
        .push_item (fifo_push_item),
        .pop       (fifo_pop),
        .not_empty (fifo_not_empty),
        .head_item (fifo_head),
        .count     (fifo_count)
    );

    assign char_out.valid          = fifo_not_empty;
    assign char_out.char_valid     = fifo_head.char_valid;
    assign char_out.char_code      = fifo_head.char_code;
    assign char_out.dropped_oldest = fifo_head.dropped_oldest;
    assign char_out.fill_level     = fifo_head.fill_level;

    a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (fifo_count != 2'd3 || fifo_pop))
        else $error("result queue overflow");

    a_level_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= BUFFER_DEPTH - 1)
        else $error("ring fill count out of range");

    a_drop_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        do_store && ring_full |=> count_reg == PTR_W'(BUFFER_DEPTH - 1))
        else $error("overwrite changed the fill level");

    a_no_char_no_code: assert property (@(posedge clk) disable iff (!rst_n)
        char_out.valid && !char_out.char_valid |->
            (char_out.char_code == ps2a_pkg::ASCII_NUL && !char_out.dropped_oldest))
        else $error("empty result carries a character");

endmodule

@@ src/ps2a_res_fifo.sv @@
// Three-entry result queue that decouples the output handshake from the input side.
module ps2a_res_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  ps2a_pkg::res_item_t push_item,
    input  logic                pop,
    output logic                not_empty,
    output ps2a_pkg::res_item_t head_item,
    output logic [1:0]          count
);

    ps2a_pkg::res_item_t slot_reg [ps2a_pkg::RES_DEPTH];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    function automatic logic [1:0] wrap_inc(input logic [1:0] p);
        return (p == 2'(ps2a_pkg::RES_DEPTH - 1)) ? 2'd0 : p + 2'd1;
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? wrap_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? wrap_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign not_empty = (count_reg != 2'd0);
    assign head_item = slot_reg[rd_ptr_reg];
    assign count     = count_reg;

endmodule

@@ verif/ps2_char_checker.sv @@
// Scoreboard for the scancode translator: predicts every result and checks char_out.
module ps2_char_checker #(
    parameter int RING_DEPTH = 256
) (
    input  logic clk,
    input  logic rst_n,
    ps2a_req_if  scan_in,
    ps2a_res_if  char_out,
    output int   errors,
    output int   pending
);
    import ps2a_pkg::*;

    res_item_t  expected_q[$];
    logic [6:0] ring_q[$];
    logic       prefix_armed = 1'b0;
    int         fail_count = 0;

    // Set-1 make code to lower-case ASCII, built from the keyboard rows.
    function automatic logic [6:0] key_char(input logic [7:0] sc);
        string      digit_row = "1234567890";
        string      top_row   = "qwertyuiop";
        string      home_row  = "asdfghjkl";
        string      low_row   = "zxcvbnm";
        logic [6:0] ch;
        ch = ASCII_NUL;
        if (sc >= 8'h02 && sc <= 8'h0B)
            ch = 7'(digit_row[sc - 8'h02]);
        else if (sc >= 8'h10 && sc <= 8'h19)
            ch = 7'(top_row[sc - 8'h10]);
        else if (sc >= 8'h1E && sc <= 8'h26)
            ch = 7'(home_row[sc - 8'h1E]);
        else if (sc >= 8'h2C && sc <= 8'h32)
            ch = 7'(low_row[sc - 8'h2C]);
        else
        begin
            case (sc)
                8'h01: ch = 7'h1B;  // escape
                8'h0C: ch = 7'h2D;  // minus
                8'h0D: ch = 7'h3D;  // equals
                8'h0E: ch = 7'h08;  // backspace
                8'h0F: ch = 7'h09;  // tab
                8'h1A: ch = 7'h5B;  // open bracket
                8'h1B: ch = 7'h5D;  // close bracket
                8'h1C: ch = 7'h0A;  // enter
                8'h27: ch = 7'h3B;  // semicolon
                8'h28: ch = 7'h27;  // quote
                8'h29: ch = 7'h60;  // backtick
                8'h2B: ch = 7'h5C;  // backslash
                8'h33: ch = 7'h2C;  // comma
                8'h34: ch = 7'h2E;  // period
                8'h35: ch = 7'h2F;  // slash
                8'h39: ch = 7'h20;  // space
                default: ch = ASCII_NUL;
            endcase
        end
        return ch;
    endfunction

    // Advance the prefix flag and the ring by one transfer and build its result.
    function automatic res_item_t predict_char(input logic kind, input logic [7:0] sc);
        res_item_t  r;
        logic [6:0] ch;
        r = '0;
        if (kind == KIND_SCAN)
        begin
            if (prefix_armed)
            begin
                prefix_armed = 1'b0;
                ch = (sc == SC_DELETE) ? ASCII_DEL : ASCII_NUL;
            end
            else if (sc == SC_PREFIX)
            begin
                prefix_armed = 1'b1;
                ch = ASCII_NUL;
            end
            else
                ch = key_char(sc);
            if (ch != ASCII_NUL)
            begin
                // full ring: drop the oldest character
                if (ring_q.size() == RING_DEPTH - 1)
                begin
                    void'(ring_q.pop_front());
                    r.dropped_oldest = 1'b1;
                end
                ring_q.push_back(ch);
                r.char_valid = 1'b1;
                r.char_code  = ch;
            end
        end
        else if (ring_q.size() != 0)
        begin
            r.char_code  = ring_q.pop_front();
            r.char_valid = 1'b1;
        end
        r.fill_level = (ring_q.size() > 255) ? 8'hFF : 8'(ring_q.size());
        return r;
    endfunction

    function automatic void check_field(input string field, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin : watch
        res_item_t want;
        if (!rst_n)
        begin
            expected_q.delete();
            ring_q.delete();
            prefix_armed = 1'b0;
        end
        else
        begin
            if (scan_in.valid && scan_in.ready)
                expected_q.push_back(predict_char(scan_in.kind, scan_in.scan_byte));
            if (char_out.valid && char_out.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result transfer with no request outstanding");
                    fail_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("char_valid", want.char_valid, char_out.char_valid);
                    check_field("char_code", want.char_code, char_out.char_code);
                    check_field("dropped_oldest", want.dropped_oldest, char_out.dropped_oldest);
                    check_field("fill_level", want.fill_level, char_out.fill_level);
                end
            end
        end
        errors  <= fail_count;
        pending <= expected_q.size();
    end

endmodule

@@ verif/tb_ps2_scancode_to_ascii_fifo.sv @@
// Testbench top: clock, reset, scancode and read stimulus, result-side stalls and verdict.
module tb_ps2_scancode_to_ascii_fifo;
    import ps2a_pkg::*;

    localparam int LONG_HOLD = 80;

    logic clk = 1'b0;
    logic rst_n;
    logic hold_req = 1'b0;
    logic hold_ack;
    int   hold_left;
    int   idle_pct = 0;
    int   stall_pct = 0;
    int   n_sent = 0;
    int   err_count;
    int   pending;

    ps2a_req_if scan_in ();
    ps2a_res_if char_out ();

    ps2_scancode_to_ascii_fifo dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .scan_in  (scan_in),
        .char_out (char_out)
    );

    ps2_char_checker scoreboard (
        .clk      (clk),
        .rst_n    (rst_n),
        .scan_in  (scan_in),
        .char_out (char_out),
        .errors   (err_count),
        .pending  (pending)
    );

    always #4 clk = ~clk;

    initial
    begin
        #3_000_000;
        $display("[ps2_scancode_to_ascii_fifo] ERROR");
        $finish;
    end

    // Result side: random stalls, plus a long hold-off whenever hold_req toggles.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            char_out.ready <= 1'b0;
            hold_left      <= 0;
            hold_ack       <= hold_req;
        end
        else if (hold_req != hold_ack)
        begin
            hold_ack       <= hold_req;
            hold_left      <= LONG_HOLD;
            char_out.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left      <= hold_left - 1;
            char_out.ready <= 1'b0;
        end
        else
            char_out.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    task automatic send(input logic kind, input logic [7:0] sc);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            scan_in.valid <= 1'b0;
            @(posedge clk);
        end
        scan_in.valid     <= 1'b1;
        scan_in.kind      <= kind;
        scan_in.scan_byte <= sc;
        @(posedge clk);
        while (!scan_in.ready)
            @(posedge clk);
        n_sent++;
    endtask

    // A read at read_pct percent; otherwise mostly key make codes, some breaks and extended sequences, the rest noise.
    task automatic send_random(input int read_pct);
        int pick;
        int tail;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < read_pct)
            send(KIND_READ, 8'($urandom));
        else if (pick < 60)
            send(KIND_SCAN, 8'($urandom_range(1, 8'h39)));
        else if (pick < 75)
            send(KIND_SCAN, SC_BREAK | 8'($urandom_range(1, 8'h39)));
        else if (pick < 85)
        begin
            send(KIND_SCAN, SC_PREFIX);
            // a read in between must leave the prefix armed
            if ($urandom_range(0, 9) == 0)
                send(KIND_READ, 8'($urandom));
            tail = $urandom_range(0, 99);
            if (tail < 50)
                send(KIND_SCAN, SC_DELETE);
            else if (tail < 65)
                send(KIND_SCAN, SC_DELETE | SC_BREAK);
            else if (tail < 75)
                send(KIND_SCAN, SC_PREFIX);
            else
                send(KIND_SCAN, 8'($urandom));
        end
        else
            send(KIND_SCAN, 8'($urandom));
    endtask

    task automatic wait_for_results();
        int guard;
        guard = 0;
        scan_in.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0 && guard < 50000)
        begin
            @(posedge clk);
            guard++;
        end
    endtask

    task automatic run_phase(input int items, input int idle, input int stall,
                             input int read_pct);
        int target;
        target    = n_sent + items;
        idle_pct  = idle;
        stall_pct <= stall;
        while (n_sent < target)
            send_random(read_pct);
        wait_for_results();
    endtask

    initial
    begin
        logic [8:0] directed_items [25];
        directed_items = '{
            {KIND_READ, 8'hFF},                       // read while empty
            {KIND_SCAN, 8'h01}, {KIND_SCAN, 8'h02}, {KIND_SCAN, 8'h0B},
            {KIND_SCAN, 8'h39}, {KIND_SCAN, 8'h1C}, {KIND_SCAN, 8'h2B},
            {KIND_SCAN, 8'h00}, {KIND_SCAN, 8'h3A}, {KIND_SCAN, 8'h7F},
            {KIND_SCAN, 8'h81}, {KIND_SCAN, 8'hFF},
            {KIND_SCAN, SC_PREFIX}, {KIND_SCAN, SC_DELETE},
            {KIND_SCAN, SC_PREFIX}, {KIND_SCAN, SC_DELETE | SC_BREAK},
            {KIND_SCAN, SC_PREFIX}, {KIND_SCAN, SC_PREFIX}, {KIND_SCAN, 8'h10},
            {KIND_SCAN, SC_PREFIX}, {KIND_READ, 8'h00}, {KIND_SCAN, SC_DELETE},
            {KIND_READ, 8'h55}, {KIND_READ, 8'hAA}, {KIND_READ, 8'h00}
        };

        rst_n = 1'b0;
        scan_in.valid     <= 1'b0;
        scan_in.kind      <= KIND_SCAN;
        scan_in.scan_byte <= 8'h00;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_items[i])
            send(directed_items[i][8], directed_items[i][7:0]);
        wait_for_results();

        // hold the result side off while the sender keeps pushing
        hold_req <= ~hold_req;
        run_phase(140, 0, 0, 40);
        run_phase(520, 58, 0, 1);
        run_phase(300, 0, 58, 90);
        run_phase(140, 25, 25, 40);

        stall_pct <= 0;
        wait_for_results();
        repeat (10) @(posedge clk);
        if (pending != 0)
            $error("%0d results never arrived", pending);
        if (err_count == 0 && pending == 0)
            $display("[ps2_scancode_to_ascii_fifo] OK");
        else
            $display("[ps2_scancode_to_ascii_fifo] ERROR");
        $finish;
    end

endmodule
